FILE: sv/water_level_rate_tracker_macros.svh
// Assertion macros for the water level rate tracker.
// Each macro expects i_clk and i_rst_n in scope where it is used.
`ifndef WATER_LEVEL_RATE_TRACKER_MACROS_SVH
`define WATER_LEVEL_RATE_TRACKER_MACROS_SVH

// Same-cycle implication, quiet during reset
`define WLRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define WLRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/wlrt_pkg.sv
// Shared types and constants for the water level rate tracker.
// No dependencies; the other files, apart from the assertion macros, refer to this package by scoped names.
`timescale 1ns / 1ps

package wlrt_pkg;

    // field widths
    localparam int ECHO_W     = 15;
    localparam int ELAPSED_W  = 24;
    localparam int LEVEL_W    = 16;
    localparam int VEL_W      = 24;
    localparam int SLEEP_W    = 16;
    localparam int DIST_W     = 18;
    localparam int COV_W      = 24;
    localparam int NOISE_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // arithmetic unit widths
    localparam int DIV_NUM_W = 41;
    localparam int DIV_DEN_W = 26;
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = 42;
    localparam int GAIN_W    = 17;

    // echo width to distance: us * 4456 >> 10 gives cm in Q8
    localparam logic [12:0] DIST_SCALE = 13'd4456;
    localparam int          DIST_SHIFT = 10;
    localparam logic [15:0] MS_PER_MIN = 16'd60000;
    localparam logic [COV_W-1:0]  COV_ONE  = 24'd65536;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
    localparam int MIN_VALID = 3;

    // register reset values
    localparam logic [15:0] RST_FULL_HEIGHT = 16'd51200;
    localparam logic [23:0] RST_PROC_NOISE  = 24'd3277;
    localparam logic [23:0] RST_SENS_NOISE  = 24'd131072;
    localparam logic [15:0] RST_SPEED_LIMIT = 16'd256;
    localparam logic [15:0] RST_SLEEP_LONG  = 16'd15;
    localparam logic [15:0] RST_SLEEP_SHORT = 16'd5;
    localparam logic [15:0] RST_INTERVAL    = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_HEIGHT    = 3'd0,
        REG_PROCESS_NOISE  = 3'd1,
        REG_SENSOR_NOISE   = 3'd2,
        REG_SPEED_LIMIT    = 3'd3,
        REG_SLEEP_LONGEST  = 3'd4,
        REG_SLEEP_SHORTEST = 3'd5,
        REG_SPEED_INTERVAL = 3'd6
    } t_reg_idx;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLOSE,
        OP_SEED,
        OP_INVAL,
        OP_KPREP,
        OP_KDIV,
        OP_KGAIN,
        OP_KMUL,
        OP_KEST,
        OP_KCOV,
        OP_VCHK,
        OP_VDIV,
        OP_VSAT,
        OP_DEC,
        OP_SDIV,
        OP_SFIN,
        OP_LOAD
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic seeded;
        logic ok;
        logic div_done;
        logic vel_due;
        logic active;
    } t_status;

endpackage

FILE: sv/wlrt_if.sv
// Channel interfaces for the water level rate tracker: echoes in, results out,
// register writes. Depends on wlrt_pkg for field widths.
`timescale 1ns / 1ps

interface wlrt_in_if;
    logic                            valid;
    logic                            ready;
    logic [wlrt_pkg::ECHO_W-1:0]     echo_us;
    logic                            burst_end;
    logic [wlrt_pkg::ELAPSED_W-1:0]  elapsed_ms;

    modport source (output valid, echo_us, burst_end, elapsed_ms, input ready);
    modport sink   (input valid, echo_us, burst_end, elapsed_ms, output ready);
endinterface

interface wlrt_out_if;
    logic                                valid;
    logic                                ready;
    logic                                reading_ok;
    logic                                first_measure;
    logic [wlrt_pkg::LEVEL_W-1:0]        level;
    logic signed [wlrt_pkg::VEL_W-1:0]   velocity;
    logic                                stay_active;
    logic [wlrt_pkg::SLEEP_W-1:0]        sleep_seconds;

    modport source (output valid, reading_ok, first_measure, level, velocity,
                    stay_active, sleep_seconds, input ready);
    modport sink   (input valid, reading_ok, first_measure, level, velocity,
                    stay_active, sleep_seconds, output ready);
endinterface

interface wlrt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wlrt_pkg::CFG_IDX_W-1:0]   index;
    logic [wlrt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/wlrt_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wlrt_pkg for operand widths.
`timescale 1ns / 1ps

module wlrt_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [wlrt_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [wlrt_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                             o_done,
    output logic [wlrt_pkg::DIV_NUM_W-1:0]   o_quo
);
    localparam int NUM_W = wlrt_pkg::DIV_NUM_W;
    localparam int DEN_W = wlrt_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           take;

    // shift in the next numerator bit and trial-subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        take    = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: sv/wlrt_dp.sv
// Datapath: sorted echo store, filter state, shared multiplier, divider and
// result registers. Depends on wlrt_pkg and wlrt_div.
`timescale 1ns / 1ps

module wlrt_dp #(
    parameter int BURST_LEN = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wlrt_pkg::t_cmd                       i_cmd,
    output wlrt_pkg::t_status                    o_status,
    input  logic [wlrt_pkg::ECHO_W-1:0]          i_echo_us,
    input  logic [wlrt_pkg::ELAPSED_W-1:0]       i_elapsed_ms,
    input  logic                                 i_cfg_we,
    input  logic [wlrt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wlrt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_reading_ok,
    output logic                                 o_first_measure,
    output logic [wlrt_pkg::LEVEL_W-1:0]         o_level,
    output logic signed [wlrt_pkg::VEL_W-1:0]    o_velocity,
    output logic                                 o_stay_active,
    output logic [wlrt_pkg::SLEEP_W-1:0]         o_sleep_seconds
);
    localparam int IDX_W  = $clog2(BURST_LEN);
    localparam int CNT_W  = $clog2(BURST_LEN + 1);
    localparam int DIST_W = wlrt_pkg::DIST_W;
    localparam int PROD_W = wlrt_pkg::PROD_W;
    localparam int NUM_W  = wlrt_pkg::DIV_NUM_W;
    localparam int DEN_W  = wlrt_pkg::DIV_DEN_W;
    localparam int GAIN_W = wlrt_pkg::GAIN_W;
    localparam int VEL_W  = wlrt_pkg::VEL_W;

    function automatic logic [15:0] clamp_level(input logic [DIST_W-1:0] d,
                                                input logic [15:0] h);
        logic [15:0] lv;
        if (d > {2'b00, h}) lv = '0;
        else                lv = h - d[15:0];
        return lv;
    endfunction

    // configuration registers
    logic [15:0] r_full, r_limit, r_long, r_short, r_interval;
    logic [23:0] r_q, r_r;

    // burst store and counters
    logic [DIST_W-1:0] r_store [BURST_LEN];
    logic [CNT_W-1:0]  r_vcnt, r_scnt;

    // filter state
    logic              r_seeded;
    logic [DIST_W-1:0] r_est;
    logic [23:0]       r_cov;
    logic [15:0]       r_ref;
    logic [VEL_W-1:0]  r_held;

    // working registers
    logic              r_ok;
    logic [DIST_W-1:0] r_median;
    logic [23:0]       r_elapsed;
    logic [24:0]       r_p;
    logic [DEN_W-1:0]  r_den;
    logic              r_dneg;
    logic [DIST_W-1:0] r_dmag;
    logic [GAIN_W-1:0] r_k;
    logic [PROD_W-1:0] r_prod;
    logic [15:0]       r_level;
    logic              r_vneg;
    logic [VEL_W-1:0]  r_v;

    // result and output registers
    logic              r_res_ok, r_res_first, r_res_active;
    logic [15:0]       r_res_level, r_res_sleep;
    logic [VEL_W-1:0]  r_res_v;
    logic              r_out_ok, r_out_first, r_out_active;
    logic [15:0]       r_out_level, r_out_sleep;
    logic [VEL_W-1:0]  r_out_v;

    // echo distance and sorted insertion
    logic [27:0]         dist_full;
    logic [DIST_W-1:0]   echo_dist;
    logic [BURST_LEN-1:0] le;
    logic [DIST_W-1:0]   n_store [BURST_LEN];
    logic                store_en;

    always_comb begin
        dist_full = 28'(i_echo_us) * 28'(wlrt_pkg::DIST_SCALE);
        echo_dist = dist_full[27:wlrt_pkg::DIST_SHIFT];
        store_en  = i_cmd.accept && (r_scnt < CNT_W'(BURST_LEN)) && (i_echo_us != '0)
                    && (r_vcnt < CNT_W'(BURST_LEN));
        for (int i = 0; i < BURST_LEN; i++) begin
            le[i] = (CNT_W'(i) < r_vcnt) && (r_store[i] <= echo_dist);
        end
        n_store[0] = le[0] ? r_store[0] : echo_dist;
        for (int i = 1; i < BURST_LEN; i++) begin
            if (le[i])            n_store[i] = r_store[i];
            else if (le[i-1])     n_store[i] = echo_dist;
            else                  n_store[i] = r_store[i-1];
        end
    end

    // shared multiplier operands
    logic [wlrt_pkg::MUL_A_W-1:0] mul_a;
    logic [wlrt_pkg::MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]            mul_p;

    // divider
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;

    // miscellaneous combinational values
    logic [IDX_W-1:0]         mid;
    logic [CNT_W-1:0]         half;
    logic [DIST_W-1:0]        seed_med;
    logic [15:0]              seed_lvl;
    logic [24:0]              p_sum;
    logic [DIST_W:0]          kdiff;
    logic signed [43:0]       sprod, kstep, enext;
    logic [DIST_W-1:0]        est_next;
    logic [PROD_W:0]          cov_sum;
    logic [26:0]              cov_c;
    logic [16:0]              dlev;
    logic [15:0]              dlev_mag;
    logic [23:0]              dt;
    logic [VEL_W-1:0]         v_sat;
    logic [VEL_W-1:0]         vmag;
    logic                     vel_due, active;
    logic [15:0]              sdiff, sleep_fin;

    always_comb begin
        half     = r_vcnt >> 1;
        mid      = half[IDX_W-1:0];
        seed_med = r_ok ? r_median : {2'b00, r_full};
        seed_lvl = clamp_level(seed_med, r_full);
        p_sum    = {1'b0, r_cov} + {1'b0, r_q};
        kdiff    = {1'b0, r_median} - {1'b0, r_est};

        // signed correction, rounded half up, then clamped to the estimate range
        sprod    = r_dneg ? -$signed({2'b00, r_prod}) : $signed({2'b00, r_prod});
        kstep    = (sprod + 44'sd32768) >>> 16;
        enext    = $signed({26'b0, r_est}) + kstep;
        if (enext < 44'sd0)                       est_next = '0;
        else if (enext > $signed({26'b0, {DIST_W{1'b1}}})) est_next = '1;
        else                                      est_next = enext[DIST_W-1:0];

        cov_sum  = {1'b0, r_prod} + (PROD_W+1)'(32768);
        cov_c    = cov_sum[42:16];

        dlev     = {1'b0, r_level} - {1'b0, r_ref};
        dlev_mag = dlev[16] ? 16'(-dlev) : dlev[15:0];
        dt       = (r_elapsed == '0) ? 24'd1 : r_elapsed;
        vel_due  = r_elapsed >= {8'b0, r_interval};

        // saturate the rounded quotient with its sign
        if (r_vneg) begin
            v_sat = (div_quo > NUM_W'(24'h800000)) ? 24'h800000 : (24'd0 - div_quo[23:0]);
        end else begin
            v_sat = (div_quo > NUM_W'(24'h7FFFFF)) ? 24'h7FFFFF : div_quo[23:0];
        end

        vmag     = r_v[VEL_W-1] ? (24'd0 - r_v) : r_v;
        active   = vmag >= {8'b0, r_limit};
        sdiff    = (r_long >= r_short) ? (r_long - r_short) : (r_short - r_long);
        sleep_fin = (r_long >= r_short) ? (r_long - div_quo[15:0])
                                        : (r_long + div_quo[15:0]);
    end

    // multiplier operand selection
    always_comb begin
        case (i_cmd.op)
            wlrt_pkg::OP_KMUL: begin
                mul_a = 25'(r_dmag);
                mul_b = r_k;
            end
            wlrt_pkg::OP_KEST: begin
                mul_a = r_p;
                mul_b = wlrt_pkg::GAIN_ONE - r_k;
            end
            wlrt_pkg::OP_VCHK: begin
                mul_a = 25'(dlev_mag);
                mul_b = 17'(wlrt_pkg::MS_PER_MIN);
            end
            wlrt_pkg::OP_DEC: begin
                mul_a = 25'(sdiff);
                mul_b = 17'(vmag[15:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (i_cmd.op)
            wlrt_pkg::OP_KDIV: begin
                div_start = 1'b1;
                div_num   = {r_p, 16'b0};
                div_den   = r_den;
            end
            wlrt_pkg::OP_VDIV: begin
                div_start = 1'b1;
                div_num   = NUM_W'(r_prod[32:0]) + NUM_W'(dt >> 1);
                div_den   = DEN_W'(dt);
            end
            wlrt_pkg::OP_SDIV: begin
                div_start = 1'b1;
                div_num   = NUM_W'(r_prod);
                div_den   = DEN_W'(r_limit);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    wlrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // configuration, counters and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= wlrt_pkg::RST_FULL_HEIGHT;
            r_q        <= wlrt_pkg::RST_PROC_NOISE;
            r_r        <= wlrt_pkg::RST_SENS_NOISE;
            r_limit    <= wlrt_pkg::RST_SPEED_LIMIT;
            r_long     <= wlrt_pkg::RST_SLEEP_LONG;
            r_short    <= wlrt_pkg::RST_SLEEP_SHORT;
            r_interval <= wlrt_pkg::RST_INTERVAL;
            r_vcnt     <= '0;
            r_scnt     <= '0;
            r_seeded   <= 1'b0;
            r_est      <= '0;
            r_cov      <= wlrt_pkg::COV_ONE;
            r_ref      <= '0;
            r_held     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (wlrt_pkg::t_reg_idx'(i_cfg_index))
                    wlrt_pkg::REG_FULL_HEIGHT:    r_full     <= i_cfg_data[15:0];
                    wlrt_pkg::REG_PROCESS_NOISE:  r_q        <= i_cfg_data;
                    wlrt_pkg::REG_SENSOR_NOISE:   r_r        <= i_cfg_data;
                    wlrt_pkg::REG_SPEED_LIMIT:    r_limit    <= i_cfg_data[15:0];
                    wlrt_pkg::REG_SLEEP_LONGEST:  r_long     <= i_cfg_data[15:0];
                    wlrt_pkg::REG_SLEEP_SHORTEST: r_short    <= i_cfg_data[15:0];
                    wlrt_pkg::REG_SPEED_INTERVAL: r_interval <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept && (r_scnt < CNT_W'(BURST_LEN))) begin
                r_scnt <= r_scnt + 1'b1;
                if (store_en) r_vcnt <= r_vcnt + 1'b1;
            end
            case (i_cmd.op)
                wlrt_pkg::OP_CLOSE: begin
                    r_vcnt <= '0;
                    r_scnt <= '0;
                end
                wlrt_pkg::OP_SEED: begin
                    r_est    <= seed_med;
                    r_cov    <= wlrt_pkg::COV_ONE;
                    r_ref    <= seed_lvl;
                    r_held   <= '0;
                    r_seeded <= 1'b1;
                end
                wlrt_pkg::OP_KEST: r_est <= est_next;
                wlrt_pkg::OP_KCOV: r_cov <= (cov_c > 27'hFFFFFF) ? 24'hFFFFFF : cov_c[23:0];
                wlrt_pkg::OP_VSAT: begin
                    r_held <= v_sat;
                    r_ref  <= r_level;
                end
                default: ;
            endcase
        end
    end

    // store insertion, working values and results
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            for (int i = 0; i < BURST_LEN; i++) r_store[i] <= n_store[i];
        end
        if (i_cmd.accept) r_elapsed <= i_elapsed_ms;
        case (i_cmd.op)
            wlrt_pkg::OP_CLOSE: begin
                r_ok     <= r_vcnt >= CNT_W'(wlrt_pkg::MIN_VALID);
                r_median <= r_store[mid];
            end
            wlrt_pkg::OP_SEED: begin
                r_res_ok     <= r_ok;
                r_res_first  <= 1'b1;
                r_res_level  <= seed_lvl;
                r_res_v      <= '0;
                r_res_active <= 1'b0;
                r_res_sleep  <= r_long;
            end
            wlrt_pkg::OP_INVAL: begin
                r_res_ok     <= 1'b0;
                r_res_first  <= 1'b0;
                r_res_level  <= '0;
                r_res_v      <= '0;
                r_res_active <= 1'b0;
                r_res_sleep  <= r_short;
            end
            wlrt_pkg::OP_KPREP: begin
                r_p    <= p_sum;
                r_den  <= {1'b0, p_sum} + {2'b00, r_r};
                r_dneg <= kdiff[DIST_W];
                r_dmag <= kdiff[DIST_W] ? DIST_W'(-kdiff) : kdiff[DIST_W-1:0];
            end
            wlrt_pkg::OP_KGAIN: r_k <= (r_den == '0) ? '0 : div_quo[GAIN_W-1:0];
            wlrt_pkg::OP_KMUL:  r_prod <= mul_p;
            wlrt_pkg::OP_KEST:  r_prod <= mul_p;
            wlrt_pkg::OP_KCOV: begin
                r_level     <= clamp_level(r_est, r_full);
                r_res_level <= clamp_level(r_est, r_full);
                r_res_ok    <= 1'b1;
                r_res_first <= 1'b0;
            end
            wlrt_pkg::OP_VCHK: begin
                r_prod <= mul_p;
                r_vneg <= dlev[16];
                if (!vel_due) r_v <= r_held;
            end
            wlrt_pkg::OP_VSAT: r_v <= v_sat;
            wlrt_pkg::OP_DEC: begin
                r_prod       <= mul_p;
                r_res_v      <= r_v;
                r_res_active <= active;
                r_res_sleep  <= '0;
            end
            wlrt_pkg::OP_SFIN: r_res_sleep <= sleep_fin;
            wlrt_pkg::OP_LOAD: begin
                r_out_ok     <= r_res_ok;
                r_out_first  <= r_res_first;
                r_out_level  <= r_res_level;
                r_out_v      <= r_res_v;
                r_out_active <= r_res_active;
                r_out_sleep  <= r_res_sleep;
            end
            default: ;
        endcase
    end

    assign o_status.seeded   = r_seeded;
    assign o_status.ok       = r_ok;
    assign o_status.div_done = div_done;
    assign o_status.vel_due  = vel_due;
    assign o_status.active   = active;

    assign o_reading_ok    = r_out_ok;
    assign o_first_measure = r_out_first;
    assign o_level         = r_out_level;
    assign o_velocity      = $signed(r_out_v);
    assign o_stay_active   = r_out_active;
    assign o_sleep_seconds = r_out_sleep;

endmodule

FILE: sv/wlrt_ctrl.sv
// Controller: sequences burst closing, filter update, velocity and sleep
// decision, and owns the echo and result handshakes. Depends on wlrt_pkg.
`timescale 1ns / 1ps

module wlrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wlrt_pkg::t_status i_status,
    output wlrt_pkg::t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_CLOSE, S_BRANCH, S_SEED, S_INVAL,
        S_KPREP, S_KDIV, S_KWAIT, S_KGAIN, S_KMUL, S_KEST, S_KCOV,
        S_VCHK, S_VDIV, S_VWAIT, S_VSAT, S_DEC,
        S_SDIV, S_SWAIT, S_SFIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept, out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // next state and command
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = accept;
        o_cmd.op     = wlrt_pkg::OP_NONE;
        case (r_state)
            S_IDLE:   if (accept && i_in_last) n_state = S_CLOSE;
            S_CLOSE: begin
                o_cmd.op = wlrt_pkg::OP_CLOSE;
                n_state  = S_BRANCH;
            end
            S_BRANCH: begin
                if (!i_status.seeded)  n_state = S_SEED;
                else if (!i_status.ok) n_state = S_INVAL;
                else                   n_state = S_KPREP;
            end
            S_SEED: begin
                o_cmd.op = wlrt_pkg::OP_SEED;
                n_state  = S_OUT;
            end
            S_INVAL: begin
                o_cmd.op = wlrt_pkg::OP_INVAL;
                n_state  = S_OUT;
            end
            S_KPREP: begin
                o_cmd.op = wlrt_pkg::OP_KPREP;
                n_state  = S_KDIV;
            end
            S_KDIV: begin
                o_cmd.op = wlrt_pkg::OP_KDIV;
                n_state  = S_KWAIT;
            end
            S_KWAIT:  if (i_status.div_done) n_state = S_KGAIN;
            S_KGAIN: begin
                o_cmd.op = wlrt_pkg::OP_KGAIN;
                n_state  = S_KMUL;
            end
            S_KMUL: begin
                o_cmd.op = wlrt_pkg::OP_KMUL;
                n_state  = S_KEST;
            end
            S_KEST: begin
                o_cmd.op = wlrt_pkg::OP_KEST;
                n_state  = S_KCOV;
            end
            S_KCOV: begin
                o_cmd.op = wlrt_pkg::OP_KCOV;
                n_state  = S_VCHK;
            end
            S_VCHK: begin
                o_cmd.op = wlrt_pkg::OP_VCHK;
                n_state  = i_status.vel_due ? S_VDIV : S_DEC;
            end
            S_VDIV: begin
                o_cmd.op = wlrt_pkg::OP_VDIV;
                n_state  = S_VWAIT;
            end
            S_VWAIT:  if (i_status.div_done) n_state = S_VSAT;
            S_VSAT: begin
                o_cmd.op = wlrt_pkg::OP_VSAT;
                n_state  = S_DEC;
            end
            S_DEC: begin
                o_cmd.op = wlrt_pkg::OP_DEC;
                n_state  = i_status.active ? S_OUT : S_SDIV;
            end
            S_SDIV: begin
                o_cmd.op = wlrt_pkg::OP_SDIV;
                n_state  = S_SWAIT;
            end
            S_SWAIT:  if (i_status.div_done) n_state = S_SFIN;
            S_SFIN: begin
                o_cmd.op = wlrt_pkg::OP_SFIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.op = wlrt_pkg::OP_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready)             r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/water_level_rate_tracker.sv
// Water level rate tracker: echoes that do not close a burst are taken back to back.
// A closing echo holds the input until its result is staged: through seeding or invalidation,
// or through a full update, in which the divider runs up to three times.
// Echoes are taken while a finished result waits in the output register.
// Synchronous active-low reset loads register defaults and clears filter state.
// Depends on wlrt_pkg, wlrt_if, wlrt_ctrl, wlrt_dp and the assertion macros.
`timescale 1ns / 1ps
`include "water_level_rate_tracker_macros.svh"

module water_level_rate_tracker #(
    parameter int BURST_LEN = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wlrt_in_if.sink     i_echo,
    wlrt_out_if.source  o_result,
    wlrt_cfg_if.sink    i_cfg
);
    wlrt_pkg::t_cmd    cmd;
    wlrt_pkg::t_status status;

    // registers accept a write in any cycle
    assign i_cfg.ready = 1'b1;

    wlrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_echo.valid),
        .i_in_last   (i_echo.burst_end),
        .o_in_ready  (i_echo.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wlrt_dp #(
        .BURST_LEN (BURST_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_echo_us       (i_echo.echo_us),
        .i_elapsed_ms    (i_echo.elapsed_ms),
        .i_cfg_we        (i_cfg.valid && i_cfg.ready),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_reading_ok    (o_result.reading_ok),
        .o_first_measure (o_result.first_measure),
        .o_level         (o_result.level),
        .o_velocity      (o_result.velocity),
        .o_stay_active   (o_result.stay_active),
        .o_sleep_seconds (o_result.sleep_seconds)
    );

    // a closing echo stops further transfers until its result is staged
    `WLRT_ASSERT_NEXT(a_close_blocks, cmd.accept && i_echo.burst_end, !i_echo.ready, "echo taken during burst processing")
    // the divider only finishes while a burst is being processed
    `WLRT_ASSERT_NOW(a_div_busy, status.div_done, !i_echo.ready, "divider finished while idle")
    // staging a result always presents it
    `WLRT_ASSERT_NEXT(a_load_valid, cmd.op == wlrt_pkg::OP_LOAD, o_result.valid, "staged result not presented")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for water_level_rate_tracker: echo bursts in, filtered level,
// velocity and sleep decision out, checked against an in-bench predictor or given values.
// Depends on wlrt_pkg, the wlrt_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int  N_SLOTS      = 5;
    localparam int  ITEM_TARGET  = 600;
    localparam int  SETTLE_CYC   = 250;
    localparam longint M16 = 64'hFFFF;
    localparam longint M18 = 64'h3FFFF;
    localparam longint M24 = 64'hFFFFFF;

    typedef struct packed {
        logic                                reading_ok;
        logic                                first_measure;
        logic [wlrt_pkg::LEVEL_W-1:0]        level;
        logic [wlrt_pkg::VEL_W-1:0]          velocity;
        logic                                stay_active;
        logic [wlrt_pkg::SLEEP_W-1:0]        sleep_seconds;
    } t_reading;

    typedef struct {
        logic [wlrt_pkg::ECHO_W-1:0]    echo;
        logic                           last;
        logic [wlrt_pkg::ELAPSED_W-1:0] elapsed;
        bit                             typed;
        t_reading                       want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    wlrt_in_if  echo_if ();
    wlrt_out_if res_if ();
    wlrt_cfg_if cfg_if ();

    water_level_rate_tracker i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_echo   (echo_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // clock, 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor copy of the registers
    longint full_height, proc_noise, sens_noise, speed_limit;
    longint sleep_long, sleep_short, speed_interval;
    // predictor copy of the filter state
    longint dist_store [N_SLOTS];
    int     valid_cnt, slot_cnt;
    bit     is_seeded;
    longint estimate, error_cov, ref_level, held_vel;

    t_reading pending_readings [$];
    int       mismatches;
    int       items_sent;
    int       burst_left;
    t_row     dir_rows [$];

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic longint clamp_lvl(input longint range_cm);
        longint lv;
        lv = full_height - range_cm;
        if (lv < 0) lv = 0;
        if (lv > full_height) lv = full_height;
        return lv;
    endfunction

    // advance the filter by one echo; returns 1 when a reading is produced
    function automatic bit track_echo(input longint echo, input bit last,
                                      input longint elapsed, output t_reading r);
        longint srt [N_SLOTS];
        longint key, median, lvl, p, den, k, diff, stp, e, c, d, dt, m, q, v, mag;
        bit     ok;
        int     i, j;
        r = '0;
        if (slot_cnt < N_SLOTS) begin
            slot_cnt++;
            if (echo != 0 && valid_cnt < N_SLOTS) begin
                dist_store[valid_cnt] = (echo * 4456) >> 10;
                valid_cnt++;
            end
        end
        if (!last) return 1'b0;
        ok = valid_cnt >= 3;
        median = 0;
        if (ok) begin
            for (i = 0; i < valid_cnt; i++) srt[i] = dist_store[i];
            for (i = 1; i < valid_cnt; i++) begin
                key = srt[i];
                j = i;
                while (j > 0 && srt[j-1] > key) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = key;
            end
            median = srt[valid_cnt / 2];
        end
        valid_cnt = 0;
        slot_cnt  = 0;
        // seed on the first burst after reset
        if (!is_seeded) begin
            if (!ok) median = full_height;
            estimate  = median;
            error_cov = 65536;
            lvl       = clamp_lvl(median);
            ref_level = lvl;
            held_vel  = 0;
            is_seeded = 1'b1;
            r.reading_ok    = ok;
            r.first_measure = 1'b1;
            r.level         = lvl[15:0];
            r.sleep_seconds = sleep_long[15:0];
            return 1'b1;
        end
        if (!ok) begin
            r.sleep_seconds = sleep_short[15:0];
            return 1'b1;
        end
        // Kalman update
        p   = error_cov + proc_noise;
        den = p + sens_noise;
        k   = (den != 0) ? (p << 16) / den : 0;
        diff = median - estimate;
        stp = (k * diff + 32768) >>> 16;
        e = estimate + stp;
        if (e < 0) e = 0;
        if (e > M18) e = M18;
        estimate = e;
        c = ((65536 - k) * p + 32768) >> 16;
        error_cov = (c > M24) ? M24 : c;
        lvl = clamp_lvl(estimate);
        // velocity, held until the interval has passed
        if (elapsed >= speed_interval) begin
            d  = lvl - ref_level;
            dt = (elapsed != 0) ? elapsed : 1;
            m  = ((d < 0) ? -d : d) * 60000;
            q  = (m + dt / 2) / dt;
            if (d < 0) v = (q > 8388608) ? -8388608 : -q;
            else       v = (q > 8388607) ? 8388607 : q;
            held_vel  = v;
            ref_level = lvl;
        end else begin
            v = held_vel;
        end
        mag = (v < 0) ? -v : v;
        r.reading_ok    = 1'b1;
        r.level         = lvl[15:0];
        r.velocity      = v[23:0];
        if (mag >= speed_limit) begin
            r.stay_active   = 1'b1;
            r.sleep_seconds = '0;
        end else if (sleep_long >= sleep_short) begin
            r.sleep_seconds = 16'(sleep_long - mag * (sleep_long - sleep_short) / speed_limit);
        end else begin
            r.sleep_seconds = 16'(sleep_long + mag * (sleep_short - sleep_long) / speed_limit);
        end
        return 1'b1;
    endfunction

    // offer one echo, in bursts with random gaps between them
    task automatic send_echo(input longint echo, input bit last, input longint elapsed,
                             input bit typed = 1'b0, input t_reading want = '0);
        t_reading r;
        if (burst_left == 0) begin
            echo_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        echo_if.valid      <= 1'b1;
        echo_if.echo_us    <= echo[wlrt_pkg::ECHO_W-1:0];
        echo_if.burst_end  <= last;
        echo_if.elapsed_ms <= elapsed[wlrt_pkg::ELAPSED_W-1:0];
        do @(posedge i_clk); while (!echo_if.ready);
        items_sent++;
        if (track_echo(echo, last, elapsed, r))
            pending_readings.push_back(typed ? want : r);
    endtask

    // hold the sender until every reading is back and the block has settled
    task automatic drain();
        echo_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input wlrt_pkg::t_reg_idx idx, input longint value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value[wlrt_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            wlrt_pkg::REG_FULL_HEIGHT:    full_height    = value & M16;
            wlrt_pkg::REG_PROCESS_NOISE:  proc_noise     = value & M24;
            wlrt_pkg::REG_SENSOR_NOISE:   sens_noise     = value & M24;
            wlrt_pkg::REG_SPEED_LIMIT:    speed_limit    = value & M16;
            wlrt_pkg::REG_SLEEP_LONGEST:  sleep_long     = value & M16;
            wlrt_pkg::REG_SLEEP_SHORTEST: sleep_short    = value & M16;
            wlrt_pkg::REG_SPEED_INTERVAL: speed_interval = value & M16;
            default: ;
        endcase
    endtask

    task automatic write_all(input longint fh, input longint qn, input longint rn,
                             input longint lim, input longint lng, input longint sht,
                             input longint ivl);
        write_reg(wlrt_pkg::REG_FULL_HEIGHT, fh);
        write_reg(wlrt_pkg::REG_PROCESS_NOISE, qn);
        write_reg(wlrt_pkg::REG_SENSOR_NOISE, rn);
        write_reg(wlrt_pkg::REG_SPEED_LIMIT, lim);
        write_reg(wlrt_pkg::REG_SLEEP_LONGEST, lng);
        write_reg(wlrt_pkg::REG_SLEEP_SHORTEST, sht);
        write_reg(wlrt_pkg::REG_SPEED_INTERVAL, ivl);
    endtask

    function automatic void add_row(input longint echo, input bit last, input longint elapsed,
                                    input bit typed = 1'b0, input t_reading want = '0);
        t_row row;
        row.echo    = echo[wlrt_pkg::ECHO_W-1:0];
        row.last    = last;
        row.elapsed = elapsed[wlrt_pkg::ELAPSED_W-1:0];
        row.typed   = typed;
        row.want    = want;
        dir_rows.push_back(row);
    endfunction

    function automatic longint rand_elapsed();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return M24;
            2: return $urandom & M24;
            3: return speed_interval;
            default: return $urandom_range(0, 2 * speed_interval + 2);
        endcase
    endfunction

    // random bursts: mostly well formed around a drifting water line
    task automatic random_bursts(input int n_items);
        int     n_echo, i, target;
        longint base, echo;
        target = items_sent + n_items;
        base = $urandom_range(100, 30000);
        while (items_sent < target) begin
            if ($urandom_range(0, 3) == 0) base = $urandom_range(1, 30000);
            else if (base > 500 && base < 29500) base = base + $urandom_range(0, 800) - 400;
            case ($urandom_range(0, 9))
                0:       n_echo = $urandom_range(1, 2);
                1:       n_echo = $urandom_range(6, 9);
                default: n_echo = $urandom_range(3, 5);
            endcase
            for (i = 0; i < n_echo; i++) begin
                case ($urandom_range(0, 9))
                    0:       echo = 0;
                    1:       echo = $urandom_range(0, 30000);
                    default: echo = base + $urandom_range(0, 60) - 30;
                endcase
                if (echo < 0) echo = 0;
                if (echo > 30000) echo = 30000;
                send_echo(echo, i == n_echo - 1, rand_elapsed());
            end
        end
    endtask

    // result side stalls in moods picked afresh each time the mood counter wraps
    int stall_mood, mood_cnt;
    always @(posedge i_clk) begin
        if (mood_cnt == 0) stall_mood <= $urandom_range(0, 3);
        mood_cnt <= (mood_cnt + 1) % 64;
        case (stall_mood)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= ($urandom_range(0, 1) == 1);
            2:       res_if.ready <= ($urandom_range(0, 7) == 0);
            default: res_if.ready <= ((mood_cnt % 16) < 10);
        endcase
    end

    // compare each reading transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_readings.size() == 0) begin
                $display("MISMATCH unexpected reading at %0t", $realtime);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                if (res_if.reading_ok !== want.reading_ok)
                    report("reading_ok", res_if.reading_ok, want.reading_ok);
                if (res_if.first_measure !== want.first_measure)
                    report("first_measure", res_if.first_measure, want.first_measure);
                if (res_if.level !== want.level)
                    report("level", res_if.level, want.level);
                if (res_if.velocity !== want.velocity)
                    report("velocity", $signed(res_if.velocity), $signed(want.velocity));
                if (res_if.stay_active !== want.stay_active)
                    report("stay_active", res_if.stay_active, want.stay_active);
                if (res_if.sleep_seconds !== want.sleep_seconds)
                    report("sleep_seconds", res_if.sleep_seconds, want.sleep_seconds);
            end
        end
    end

    // hard stop
    initial begin
        #40_000_000;
        $display("water_level_rate_tracker regression: fail");
        $finish;
    end

    initial begin
        t_reading r;
        i_rst_n = 1'b0;
        echo_if.valid = 1'b0;
        echo_if.echo_us = '0;
        echo_if.burst_end = 1'b0;
        echo_if.elapsed_ms = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = wlrt_pkg::REG_FULL_HEIGHT;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
        mood_cnt = 0;
        stall_mood = 0;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;

        // predictor reset
        full_height = wlrt_pkg::RST_FULL_HEIGHT; proc_noise = wlrt_pkg::RST_PROC_NOISE;
        sens_noise = wlrt_pkg::RST_SENS_NOISE; speed_limit = wlrt_pkg::RST_SPEED_LIMIT;
        sleep_long = wlrt_pkg::RST_SLEEP_LONG; sleep_short = wlrt_pkg::RST_SLEEP_SHORT;
        speed_interval = wlrt_pkg::RST_INTERVAL;
        foreach (dist_store[i]) dist_store[i] = 0;
        valid_cnt = 0; slot_cnt = 0; is_seeded = 1'b0;
        estimate = 0; error_cov = 65536; ref_level = 0; held_vel = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: invalid first burst seeds from full height
        r = '0; r.first_measure = 1'b1; r.sleep_seconds = 16'd15;
        add_row(0, 1, 0, 1, r);
        // invalid burst once seeded
        r = '0; r.sleep_seconds = 16'd5;
        add_row(0, 1, M24, 1, r);
        // longest echoes, level clamps to zero
        add_row(30000, 0, 0); add_row(30000, 0, 0); add_row(30000, 1, 0);
        // overlong burst: slots past five are ignored
        add_row(1, 0, 0); add_row(2, 0, 0); add_row(3, 0, 0); add_row(4, 0, 0);
        add_row(5, 0, 0); add_row(16383, 0, 0); add_row(7, 1, M24);
        // timeouts mixed in, interval just reached
        add_row(10000, 0, 0); add_row(0, 0, 0); add_row(12000, 0, 0);
        add_row(0, 0, 0); add_row(11000, 1, 5000);
        // two valid echoes only
        r = '0; r.sleep_seconds = 16'd5;
        add_row(20000, 0, 0); add_row(0, 0, 0); add_row(20000, 1, 0, 1, r);
        // elapsed below interval holds velocity
        add_row(16384, 0, 0); add_row(16500, 0, 0); add_row(16400, 1, 4999);
        foreach (dir_rows[i])
            send_echo(dir_rows[i].echo, dir_rows[i].last, dir_rows[i].elapsed,
                      dir_rows[i].typed, dir_rows[i].want);

        random_bursts(130);
        // pause with the filter busy-free, then resume
        drain();
        random_bursts(30);
        drain();

        // upper extremes, sleep rising from zero, velocity every burst
        write_all(65535, 0, 1, 1, 0, 65535, 0);
        random_bursts(110);
        drain();
        // lower height, heavy noise, widest speed limit
        write_all(0, M24, M24, 65535, 65535, 0, 65535);
        random_bursts(100);
        drain();
        // mid-range setting
        write_all($urandom_range(20000, 65535), $urandom_range(0, 200000),
                  $urandom_range(1, 400000), $urandom_range(1, 3000),
                  $urandom_range(0, 100), $urandom_range(0, 100),
                  $urandom_range(0, 3000));
        random_bursts(100);
        drain();
        write_all(wlrt_pkg::RST_FULL_HEIGHT, wlrt_pkg::RST_PROC_NOISE,
                  wlrt_pkg::RST_SENS_NOISE, wlrt_pkg::RST_SPEED_LIMIT,
                  wlrt_pkg::RST_SLEEP_LONG, wlrt_pkg::RST_SLEEP_SHORT,
                  wlrt_pkg::RST_INTERVAL);
        random_bursts(ITEM_TARGET - items_sent > 60 ? ITEM_TARGET - items_sent : 60);
        drain();

        if (mismatches == 0 && pending_readings.size() == 0)
            $display("water_level_rate_tracker regression: pass");
        else
            $display("water_level_rate_tracker regression: fail");
        $finish;
    end

endmodule
